// File: rtl/core/whp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whirlpool package
// s-box, round constant lookup and the 64-bit row mix helpers
// ----------------------------------------------------------------------------
package whp_pkg;

  localparam int unsigned ROUNDS     = 10;
  localparam int unsigned BLOCK_SIZE = 64;
  localparam int unsigned LEN_LIMIT  = 32;
  localparam logic [7:0]  PAD_MARK   = 8'h80;

  // transaction opcodes
  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef logic [63:0] word_t;

  function automatic logic [3:0] mini_e(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'h1; 4'h1: r = 4'hB; 4'h2: r = 4'h9; 4'h3: r = 4'hC;
      4'h4: r = 4'hD; 4'h5: r = 4'h6; 4'h6: r = 4'hF; 4'h7: r = 4'h3;
      4'h8: r = 4'hE; 4'h9: r = 4'h8; 4'hA: r = 4'h7; 4'hB: r = 4'h4;
      4'hC: r = 4'hA; 4'hD: r = 4'h2; 4'hE: r = 4'h5; default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mini_ei(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h1: r = 4'h0; 4'hB: r = 4'h1; 4'h9: r = 4'h2; 4'hC: r = 4'h3;
      4'hD: r = 4'h4; 4'h6: r = 4'h5; 4'hF: r = 4'h6; 4'h3: r = 4'h7;
      4'hE: r = 4'h8; 4'h8: r = 4'h9; 4'h7: r = 4'hA; 4'h4: r = 4'hB;
      4'hA: r = 4'hC; 4'h2: r = 4'hD; 4'h5: r = 4'hE; default: r = 4'hF;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mini_r(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'h7; 4'h1: r = 4'hC; 4'h2: r = 4'hB; 4'h3: r = 4'hD;
      4'h4: r = 4'hE; 4'h5: r = 4'h4; 4'h6: r = 4'h9; 4'h7: r = 4'hF;
      4'h8: r = 4'h6; 4'h9: r = 4'h3; 4'hA: r = 4'h8; 4'hB: r = 4'hA;
      4'hC: r = 4'h2; 4'hD: r = 4'h5; 4'hE: r = 4'h1; default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [3:0] hi, lo, rr;
    hi = mini_e(x[7:4]);
    lo = mini_ei(x[3:0]);
    rr = mini_r(hi ^ lo);
    return {mini_e(hi ^ rr), mini_ei(lo ^ rr)};
  endfunction

  // multiply by x modulo 0x11d
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1D : 8'h00);
  endfunction

  // c0 row: s * {1,1,4,1,8,5,2,9}
  function automatic word_t c0(input logic [7:0] x);
    logic [7:0] s1, s2, s4, s8;
    s1 = sbox(x);
    s2 = xt(s1);
    s4 = xt(s2);
    s8 = xt(s4);
    return {s1, s1, s4, s1, s8, s4 ^ s1, s2, s8 ^ s1};
  endfunction

  function automatic word_t round_const(input logic [3:0] r);
    word_t w;
    logic [7:0] base;
    base = {1'b0, r, 3'b000};
    for (int j = 0; j < 8; j++) begin
      w[63-8*j -: 8] = sbox(base + 8'(j));
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/whirlpool_hash_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whirlpool hash engine
// byte-stream whirlpool-512 with padding and digest readout
// ----------------------------------------------------------------------------
// compression: the byte that fills the block starts a compression of it
// (load, then one row mix per cycle: 8 key rows and 8 state rows per round,
// 10 rounds, then feed-forward)
// finish: padding bytes complete the block, plus one more padding block when needed, then 8 digest words
// throughput: one byte per cycle between compressions; in_ready is low while a block is compressed
// reset: synchronous active-low rst_n clears chaining value and counters
module whirlpool_hash_engine_top
  import whp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic             out_digest_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_KEY, S_STATE, S_FEED, S_PAD, S_OUT
  } state_t;

  state_t      state_r;
  // block buffer: bytes shift in at the bottom, byte 0 ends at the top
  logic [8*BLOCK_SIZE-1:0] blk_r;
  logic [5:0]  fill_r;
  logic [63:0] count_r;
  word_t       hash_r [8];
  word_t       k_r [8], s_r [8], nk_r [8];
  logic [3:0]  rnd_r;
  logic [2:0]  row_r;
  logic        fin_r;                // finish in progress
  logic        last_blk_r;           // this compression ends the message
  logic [2:0]  oidx_r;

  // shared row mix: one row of one 8-word operand per cycle
  word_t       mix_src [8];
  word_t       mix_out;
  logic [7:0]  pad_byte;
  logic [5:0]  fill_inc;

  always_comb begin
    for (int i = 0; i < 8; i++) mix_src[i] = (state_r == S_KEY) ? k_r[i] : s_r[i];
    mix_out = '0;
    for (int t = 0; t < 8; t++) begin
      word_t c;
      c = c0(mix_src[3'(row_r - 3'(t))][63-8*t -: 8]);
      mix_out ^= (c >> (8*t)) | (c << (64-8*t));
    end
  end

  // padding byte at the current fill position
  always_comb begin
    fill_inc = fill_r + 6'd1;
    if (fill_r >= 6'(BLOCK_SIZE - 8) && last_blk_r)
      pad_byte = count_r[63 - 8*(fill_r[2:0]) -: 8];
    else
      pad_byte = 8'h00;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = hash_r[oidx_r];
  assign out_digest_last = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      count_r <= '0;
      fin_r   <= 1'b0;
      last_blk_r <= 1'b0;
      oidx_r  <= '0;
      rnd_r   <= '0;
      row_r   <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_op == OP_DATA) begin
              blk_r   <= {blk_r[8*BLOCK_SIZE-9:0], in_data_byte};
              fill_r  <= fill_inc;
              count_r <= count_r + 64'd1;
              if (fill_r == 6'(BLOCK_SIZE - 1)) state_r <= S_LOAD;
            end else begin
              // count becomes bit length
              count_r <= {count_r[60:0], 3'b000};
              blk_r   <= {blk_r[8*BLOCK_SIZE-9:0], PAD_MARK};
              fill_r  <= fill_inc;
              fin_r   <= 1'b1;
              last_blk_r <= (fill_r < 6'(LEN_LIMIT));
              if (fill_r == 6'(BLOCK_SIZE - 1)) state_r <= S_LOAD;
              else state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          blk_r  <= {blk_r[8*BLOCK_SIZE-9:0], pad_byte};
          fill_r <= fill_inc;
          if (fill_r == 6'(BLOCK_SIZE - 1)) state_r <= S_LOAD;
        end
        S_LOAD: begin
          for (int i = 0; i < 8; i++) begin
            k_r[i] <= hash_r[i];
            s_r[i] <= blk_r[8*BLOCK_SIZE-1-64*i -: 64] ^ hash_r[i];
          end
          rnd_r <= '0;
          row_r <= '0;
          state_r <= S_KEY;
        end
        S_KEY: begin
          nk_r[row_r] <= (row_r == 3'd0) ? (mix_out ^ round_const(rnd_r)) : mix_out;
          row_r <= row_r + 3'd1;
          if (row_r == 3'd7) begin
            for (int i = 0; i < 7; i++) k_r[i] <= nk_r[i];
            k_r[7] <= mix_out;
            state_r <= S_STATE;
          end
        end
        S_STATE: begin
          nk_r[row_r] <= mix_out ^ k_r[row_r];
          row_r <= row_r + 3'd1;
          if (row_r == 3'd7) begin
            for (int i = 0; i < 7; i++) s_r[i] <= nk_r[i];
            s_r[7] <= mix_out ^ k_r[7];
            rnd_r  <= rnd_r + 4'd1;
            if (rnd_r == 4'(ROUNDS - 1)) state_r <= S_FEED;
            else state_r <= S_KEY;
          end
        end
        S_FEED: begin
          for (int i = 0; i < 8; i++) begin
            hash_r[i] <= hash_r[i] ^ s_r[i] ^ blk_r[8*BLOCK_SIZE-1-64*i -: 64];
          end
          if (!fin_r) state_r <= S_IDLE;
          else if (last_blk_r) begin
            oidx_r  <= '0;
            state_r <= S_OUT;
          end else begin
            last_blk_r <= 1'b1;
            state_r <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_r[i] <= '0;
              fill_r <= '0;
              count_r <= '0;
              fin_r <= 1'b0;
              last_blk_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
